// ----- rtl/avgp_pkg.sv -----
// shared types and constants for the average pooling block
`timescale 1ns / 1ps
package avgp_pkg;
   localparam int MaxWidth   = 64;
   localparam int MaxKernel  = 8;
   localparam int SampleBits = 16;
   localparam int MaxDepth   = 256;
   localparam int ColBits    = $clog2(MaxWidth);
   localparam int RowSelBits = $clog2(MaxKernel);
   localparam int AddrBits   = RowSelBits + ColBits;
   localparam int SumBits    = SampleBits + 2 * RowSelBits + 1;

   localparam logic [2:0] CSR_KERNEL = 3'd0;
   localparam logic [2:0] CSR_STRIDE = 3'd1;
   localparam logic [2:0] CSR_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_DEPTH  = 3'd4;

   // one window job handed from front to back
   typedef struct packed {
      logic [ColBits-1:0]    top;
      logic [ColBits-1:0]    left;
      logic [RowSelBits-1:0] rsel;
      logic [7:0]            channel;
      logic [5:0]            out_row;
      logic [5:0]            out_col;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SUM,
      BK_DIV,
      BK_OUT
   } back_state_type;

   // reciprocal of k*k scaled by 2^28 and rounded up, k = 1..8
   function automatic logic [28:0] recip(input logic [3:0] k);
      logic [28:0] r;
      case (k)
         4'd1: r = 29'd268435456;
         4'd2: r = 29'd67108864;
         4'd3: r = 29'd29826162;
         4'd4: r = 29'd16777216;
         4'd5: r = 29'd10737419;
         4'd6: r = 29'd7456541;
         4'd7: r = 29'd5478275;
         4'd8: r = 29'd4194304;
         default: r = 29'd268435456;
      endcase
      return r;
   endfunction
endpackage

// ----- rtl/avgp_front.sv -----
// front end: position tracking, line store writes and window detection
`timescale 1ns / 1ps
module avgp_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 restart,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [3:0]                           k_eff,
   input  logic [3:0]                           s_eff,
   input  logic [6:0]                           h_eff,
   input  logic [6:0]                           w_eff,
   input  logic [8:0]                           d_eff,
   input  logic                                 hold,
   output logic                                 q_push,
   output avgp_pkg::job_type                    q_job,
   output logic                                 wr_en,
   output logic [avgp_pkg::AddrBits-1:0]        wr_addr
);
   import avgp_pkg::*;

   logic [5:0] row_ff, row_in, col_ff, col_in;
   logic [7:0] ch_ff, ch_in;
   // next position on the stride grid and output index
   logic [5:0] rgrid_ff, rgrid_in, cgrid_ff, cgrid_in;
   logic [5:0] orow_ff, orow_in, ocol_ff, ocol_in;
   // row % k tracked as counter to avoid divider
   logic [2:0] rmod_ff, rmod_in;
   logic [6:0] top, left;
   logic       acc, hit;

   assign req_stall = hold;
   assign acc = req_valid && !hold;

   always_comb begin
      top  = {1'b0, row_ff} + 7'd1 - {3'd0, k_eff};
      left = {1'b0, col_ff} + 7'd1 - {3'd0, k_eff};
      hit  = ({1'b0, row_ff} + 7'd1 >= {3'd0, k_eff}) &&
             ({1'b0, col_ff} + 7'd1 >= {3'd0, k_eff}) &&
             (top[5:0] == rgrid_ff) && (left[5:0] == cgrid_ff);
   end

   assign wr_en   = acc;
   assign wr_addr = {rmod_ff, col_ff};
   assign q_push  = acc && hit;
   always_comb begin
      q_job.top     = top[5:0];
      q_job.left    = left[5:0];
      // top % k equals (row + 1) % k
      q_job.rsel    = (4'(rmod_ff) + 4'd1 >= k_eff) ? 3'd0 : rmod_ff + 3'd1;
      q_job.channel = ch_ff;
      q_job.out_row = orow_ff;
      q_job.out_col = ocol_ff;
   end

   always_comb begin
      row_in = row_ff; col_in = col_ff; ch_in = ch_ff; rmod_in = rmod_ff;
      rgrid_in = rgrid_ff; cgrid_in = cgrid_ff; orow_in = orow_ff; ocol_in = ocol_ff;
      if (acc) begin
         if (hit) begin
            cgrid_in = cgrid_ff + 6'(s_eff);
            ocol_in  = ocol_ff + 6'd1;
         end
         if ({1'b0, col_ff} + 7'd1 >= w_eff) begin
            col_in = '0; cgrid_in = '0; ocol_in = '0;
            rmod_in = (4'(rmod_ff) + 4'd1 >= k_eff) ? 3'd0 : rmod_ff + 3'd1;
            row_in = row_ff + 6'd1;
            if ({1'b0, row_ff} + 7'd1 >= {3'd0, k_eff} &&
                top[5:0] == rgrid_ff) begin
               rgrid_in = rgrid_ff + 6'(s_eff);
               orow_in  = orow_ff + 6'd1;
            end
            if ({1'b0, row_ff} + 7'd1 >= h_eff) begin
               row_in = '0; rmod_in = '0; rgrid_in = '0; orow_in = '0;
               ch_in = ({1'b0, ch_ff} + 9'd1 >= d_eff) ? 8'd0 : ch_ff + 8'd1;
            end
         end else begin
            col_in = col_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         row_ff <= '0; col_ff <= '0; ch_ff <= '0; rmod_ff <= '0;
         rgrid_ff <= '0; cgrid_ff <= '0; orow_ff <= '0; ocol_ff <= '0;
      end else begin
         row_ff <= row_in; col_ff <= col_in; ch_ff <= ch_in; rmod_ff <= rmod_in;
         rgrid_ff <= rgrid_in; cgrid_ff <= cgrid_in;
         orow_ff <= orow_in; ocol_ff <= ocol_in;
      end
   end
endmodule

// ----- rtl/avgp_queue.sv -----
// two-entry job queue between front and back
`timescale 1ns / 1ps
module avgp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  avgp_pkg::job_type   push_job,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output avgp_pkg::job_type   head
);
   import avgp_pkg::*;

   job_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head      = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule

// ----- rtl/avgp_back.sv -----
// back end: window sum over the line store, scaling and result register
`timescale 1ns / 1ps
module avgp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [3:0]                        k_eff,
   input  logic                              q_valid,
   input  avgp_pkg::job_type                 q_job,
   output logic                              q_pop,
   input  logic                              wr_en,
   input  logic [avgp_pkg::AddrBits-1:0]     wr_addr,
   input  logic signed [15:0]                wr_data,
   output logic                              busy,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_average,
   output logic [7:0]                        rsp_channel,
   output logic [5:0]                        rsp_out_row,
   output logic [5:0]                        rsp_out_col
);
   import avgp_pkg::*;

   logic signed [15:0] store [MaxKernel*MaxWidth];
   logic signed [15:0] rd_ff;
   logic [AddrBits-1:0] rd_addr;

   back_state_type st_ff, st_in;
   job_type    job_ff;
   logic [3:0] m_ff, m_in, n_ff, n_in;
   logic [2:0] rsel_ff, rsel_in;
   logic       rdv_ff, rdv_in;
   logic signed [SumBits-1:0] sum_ff, sum_in;
   logic [SumBits-1:0]  mag;
   logic [SumBits+28:0] q_wide;
   logic signed [15:0] avg_ff;
   logic       vout_ff;
   logic       issue, last;

   // one sample read per cycle, read data registered
   assign rd_addr = {rsel_ff, 6'(job_ff.left + 6'(n_ff))};
   always_ff @(posedge clock) begin
      if (wr_en) store[wr_addr] <= wr_data;
      rd_ff <= store[rd_addr];
   end

   assign issue = st_ff == BK_SUM && m_ff < k_eff;
   assign last  = n_ff + 4'd1 >= k_eff;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_IDLE: if (q_valid) st_in = BK_SUM;
         BK_SUM:  if (!issue && !rdv_ff) st_in = BK_DIV;
         BK_DIV:  st_in = BK_OUT;
         BK_OUT:  if (!vout_ff || !rsp_stall) st_in = BK_IDLE;
         default: st_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop   = st_ff == BK_IDLE && q_valid;
      m_in = m_ff; n_in = n_ff; rsel_in = rsel_ff; sum_in = sum_ff;
      rdv_in = issue;
      if (q_pop) begin
         m_in = '0; n_in = '0; sum_in = '0;
         rsel_in = q_job.rsel;
      end
      if (rdv_ff) sum_in = sum_ff + SumBits'(rd_ff);
      if (issue) begin
         if (last) begin
            n_in = '0; m_in = m_ff + 4'd1;
            rsel_in = (4'(rsel_ff) + 4'd1 >= k_eff) ? 3'd0 : rsel_ff + 3'd1;
         end else begin
            n_in = n_ff + 4'd1;
         end
      end
      // magnitude times rounded-up reciprocal gives the exact floor here
      mag    = sum_ff[SumBits-1] ? SumBits'(-sum_ff) : sum_ff;
      q_wide = (SumBits+29)'(mag) * recip(k_eff);
   end

   always_ff @(posedge clock) begin
      if (q_pop) job_ff <= q_job;
      m_ff <= m_in; n_ff <= n_in; rsel_ff <= rsel_in; sum_ff <= sum_in;
      if (st_ff == BK_DIV) begin
         avg_ff <= sum_ff[SumBits-1] ? -16'(q_wide[SumBits+27:28])
                                     : 16'(q_wide[SumBits+27:28]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE; rdv_ff <= 1'b0; vout_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         rdv_ff <= rdv_in;
         if (st_ff == BK_DIV) vout_ff <= 1'b1;
         else if (vout_ff && !rsp_stall) vout_ff <= 1'b0;
      end
   end

   // line store reads of the current window in progress
   assign busy        = st_ff == BK_SUM;
   assign rsp_valid   = vout_ff;
   assign rsp_average = avg_ff;
   assign rsp_channel = job_ff.channel;
   assign rsp_out_row = job_ff.out_row;
   assign rsp_out_col = job_ff.out_col;
endmodule

// ----- rtl/average_pooling_2d.sv -----
// top level of the streaming 2-d average pooling block
`timescale 1ns / 1ps
// usage:
//  - req channel: one signed q8.8 sample per transaction, raster order with
//    channel outermost, then row, then column
//  - rsp channel: one transaction per completed stride-aligned window, giving
//    the mean truncated toward zero plus channel and output coordinates
//  - csr port: kernel, stride (0 = kernel), height, width, depth; a write to
//    one restarts the map at row, column and channel zero; write only when idle
//  - the front tracks positions, writes each sample to the line store and
//    queues a window job; the back sums the window one line-store read per
//    cycle, set by the single read port of the line store
//  - rsp_valid rises once the back has passed its sum and divide states
//  - while a job waits or its window is being read the front stalls, so
//    rows under the window are not overwritten
//  - samples that complete no window take one cycle each, barring a stall
//  - reset clears position counters, queue, back state and csr defaults;
//    the line store is not cleared, windows only read written entries
//  - a stalled rsp holds its result; the next job waits and the front stalls
module average_pooling_2d (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_average,
   output logic [7:0]         rsp_channel,
   output logic [5:0]         rsp_out_row,
   output logic [5:0]         rsp_out_col,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [8:0]         csr_data
);
   import avgp_pkg::*;

   logic [3:0] kernel_ff, stride_ff;
   logic [6:0] height_ff, width_ff;
   logic [8:0] depth_ff;
   logic [3:0] k_eff, s_eff;
   logic [6:0] h_eff, w_eff;
   logic [8:0] d_eff;
   logic       restart;
   logic    q_full, q_push, q_pop, q_ne, wr_en, busy, front_hold;
   job_type push_job, head_job;
   logic [AddrBits-1:0] wr_addr;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= 4'd2; stride_ff <= 4'd0;
         height_ff <= 7'd64; width_ff <= 7'd64; depth_ff <= 9'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_KERNEL: kernel_ff <= csr_data[3:0];
            CSR_STRIDE: stride_ff <= csr_data[3:0];
            CSR_HEIGHT: height_ff <= csr_data[6:0];
            CSR_WIDTH:  width_ff  <= csr_data[6:0];
            CSR_DEPTH:  depth_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // only known indexes restart the map
   assign restart = csr_write && (csr_index <= CSR_DEPTH);

   // clamp to the supported range
   always_comb begin
      k_eff = (kernel_ff == 4'd0) ? 4'd1 : (kernel_ff > 4'd8) ? 4'd8 : kernel_ff;
      s_eff = (stride_ff == 4'd0) ? k_eff : stride_ff;
      h_eff = (height_ff == 7'd0) ? 7'd1 : (height_ff > 7'd64) ? 7'd64 : height_ff;
      w_eff = (width_ff == 7'd0) ? 7'd1 : (width_ff > 7'd64) ? 7'd64 : width_ff;
      d_eff = (depth_ff == 9'd0) ? 9'd1 : (depth_ff > 9'd256) ? 9'd256 : depth_ff;
   end

   // hold the front while a window job is pending or its rows are being read
   assign front_hold = q_ne || busy;

   avgp_front u_front (
      .clock, .reset, .restart, .req_valid, .req_stall,
      .k_eff, .s_eff, .h_eff, .w_eff, .d_eff,
      .hold(front_hold), .q_push, .q_job(push_job), .wr_en, .wr_addr
   );

   avgp_queue u_queue (
      .clock, .reset, .push(q_push), .push_job, .full(q_full),
      .pop(q_pop), .not_empty(q_ne), .head(head_job)
   );

   avgp_back u_back (
      .clock, .reset, .k_eff, .q_valid(q_ne), .q_job(head_job), .q_pop,
      .wr_en, .wr_addr, .wr_data(req_sample), .busy,
      .rsp_valid, .rsp_stall, .rsp_average, .rsp_channel,
      .rsp_out_row, .rsp_out_col
   );

   // a held result stays put while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_average))
      else $error("rsp payload changed under stall");

   // queue never pushed while full
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_full))
      else $error("job queue overflow");

   // back only pops when a job waits
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_ne)
      else $error("pop of empty job queue");
endmodule

// ----- bench/tb.sv -----
// self-checking bench for the streaming 2-d average pooling block
`timescale 1ns / 1ps
module tb;
   import avgp_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_sample = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_average;
   logic [7:0]         rsp_channel;
   logic [5:0]         rsp_out_row;
   logic [5:0]         rsp_out_col;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = CSR_KERNEL;
   logic [8:0]         csr_data = '0;

   average_pooling_2d i_dut (.*);

   always #5 clock = ~clock;

   // one pooled value as the block should report it
   typedef struct packed {
      logic signed [15:0] average;
      logic [7:0]         channel;
      logic [5:0]         out_row;
      logic [5:0]         out_col;
   } pooled_type;

   pooled_type pooled_queue[$];
   int         error_count = 0;
   int         cycle_count = 0;
   int         sent_count = 0;
   bit         finished = 1'b0;

   // shadow registers and position counters of the predictor
   logic [3:0] kernel_reg;
   logic [3:0] stride_reg;
   logic [6:0] height_reg;
   logic [6:0] width_reg;
   logic [8:0] depth_reg;
   logic signed [15:0] rows_kept [MaxKernel][MaxWidth];
   int         row_pos, col_pos, chan_pos;

   function automatic int clamp_dim(input int v, input int top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   // folds one sample into the shadow line store; queues the window mean if due
   task automatic pool_sample(input logic signed [15:0] smp);
      int k, s, h, w, d, top, left;
      longint sum;
      pooled_type p;
      k = clamp_dim(kernel_reg, MaxKernel);
      s = (stride_reg == 0) ? k : stride_reg;
      h = clamp_dim(height_reg, MaxWidth);
      w = clamp_dim(width_reg, MaxWidth);
      d = clamp_dim(depth_reg, MaxDepth);
      rows_kept[row_pos % k][col_pos] = smp;
      if (row_pos + 1 >= k && col_pos + 1 >= k) begin
         top  = row_pos + 1 - k;
         left = col_pos + 1 - k;
         if (top % s == 0 && left % s == 0) begin
            sum = 0;
            for (int m = 0; m < k; m++)
               for (int n = 0; n < k; n++)
                  sum += rows_kept[(top + m) % k][left + n];
            // longint division truncates toward zero
            sum = sum / (k * k);
            p.average = sum[15:0];
            p.channel = chan_pos[7:0];
            p.out_row = 6'(top / s);
            p.out_col = 6'(left / s);
            pooled_queue.push_back(p);
         end
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) begin
            row_pos = 0;
            chan_pos++;
            if (chan_pos >= d) chan_pos = 0;
         end
      end
   endtask

   // random gap: mostly none or short, now and then long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sends one sample transaction and updates the prediction when accepted
   task automatic send_sample(input logic signed [15:0] smp);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= smp;
      do @(posedge clock); while (req_stall);
      pool_sample(smp);
      sent_count++;
   endtask

   // waits until every pooled value has come back, plus a settling pause
   task automatic drain();
      req_valid <= 1'b0;
      while (pooled_queue.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // register write while idle; a write to a known index restarts the map
   task automatic write_csr(input logic [2:0] idx, input logic [8:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         CSR_KERNEL: kernel_reg = val[3:0];
         CSR_STRIDE: stride_reg = val[3:0];
         CSR_HEIGHT: height_reg = val[6:0];
         CSR_WIDTH:  width_reg  = val[6:0];
         CSR_DEPTH:  depth_reg  = val[8:0];
         default: ;
      endcase
      row_pos = 0;
      col_pos = 0;
      chan_pos = 0;
   endtask

   task automatic set_map(input int k, input int s, input int h, input int w, input int d);
      drain();
      write_csr(CSR_KERNEL, 9'(k));
      write_csr(CSR_STRIDE, 9'(s));
      write_csr(CSR_HEIGHT, 9'(h));
      write_csr(CSR_WIDTH, 9'(w));
      write_csr(CSR_DEPTH, 9'(d));
      csr_write <= 1'b0;
   endtask

   function automatic logic signed [15:0] rand_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'sh7fff;
      if (r == 1) return 16'sh8000;
      return 16'($urandom());
   endfunction

   // reset defaults: kernel 2, stride = kernel, a full 64-wide row pair
   task automatic test_reset_defaults();
      for (int i = 0; i < 128; i++) send_sample(rand_sample());
   endtask

   // extremes of the sample, kernel 1 pass-through, saturation and zero registers
   task automatic test_directed();
      set_map(1, 0, 2, 3, 1);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'shffff);
      send_sample(16'sh5555);
      send_sample(16'shaaaa);
      // negative window means truncate toward zero
      set_map(3, 1, 3, 3, 2);
      for (int i = 0; i < 9; i++) send_sample(i == 0 ? 16'shfffe : 16'sh0000);
      for (int i = 0; i < 9; i++) send_sample(16'sh8000);
      // zero registers act as one, oversize ones saturate
      set_map(0, 0, 0, 0, 0);
      send_sample(16'sh1234);
      set_map(15, 15, 127, 2, 511);
      for (int i = 0; i < 4; i++) send_sample(rand_sample());
      // kernel wider than the map completes no window
      set_map(4, 0, 2, 2, 1);
      for (int i = 0; i < 4; i++) send_sample(rand_sample());
   endtask

   // random maps: whole maps of random samples, now and then stopped early
   task automatic test_random_maps();
      int k, s, h, w, d, n;
      while (sent_count < 950) begin
         k = $urandom_range(1, 8);
         s = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         h = $urandom_range(k, k + 6);
         w = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(k, k + 8);
         d = $urandom_range(1, 3);
         if ($urandom_range(0, 19) == 0) begin
            h = 64;
            w = 8;
            d = 1;
         end
         set_map(k, s, h, w, d);
         n = h * w * d;
         // sometimes stop mid-map so the next write restarts it
         if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
         if (sent_count + n > 950) n = 950 - sent_count;
         for (int i = 0; i < n; i++) send_sample(rand_sample());
      end
   endtask

   // receive side: random stalls, checks each pooled value in order
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pooled_queue.size() == 0) begin
               $display("%0t: unexpected result avg=%0d ch=%0d row=%0d col=%0d", $time,
                        rsp_average, rsp_channel, rsp_out_row, rsp_out_col);
               error_count++;
            end else begin
               pooled_type e;
               e = pooled_queue.pop_front();
               if (rsp_average !== e.average) begin
                  $display("%0t: average expected %0d actual %0d", $time, e.average,
                           rsp_average);
                  error_count++;
               end
               if (rsp_channel !== e.channel) begin
                  $display("%0t: channel expected %0d actual %0d", $time, e.channel,
                           rsp_channel);
                  error_count++;
               end
               if (rsp_out_row !== e.out_row) begin
                  $display("%0t: out_row expected %0d actual %0d", $time, e.out_row,
                           rsp_out_row);
                  error_count++;
               end
               if (rsp_out_col !== e.out_col) begin
                  $display("%0t: out_col expected %0d actual %0d", $time, e.out_col,
                           rsp_out_col);
                  error_count++;
               end
            end
         end
         rsp_stall <= (gap_len() != 0);
      end
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!finished && cycle_count > 2000000) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      kernel_reg = 4'd2;
      stride_reg = 4'd0;
      height_reg = 7'd64;
      width_reg  = 7'd64;
      depth_reg  = 9'd1;
      row_pos = 0;
      col_pos = 0;
      chan_pos = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed();
      test_random_maps();
      drain();
      finished = 1'b1;
      if (error_count == 0 && pooled_queue.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
